// ===== design/multi_alarm_minute_scheduler_assert.svh =====
// Assertion macros shared by the scheduler's RTL files.
// MAMS_ASSERT checks a property outside reset; MAMS_ASSERT_ALWAYS checks it at every edge.
`ifndef MULTI_ALARM_MINUTE_SCHEDULER_ASSERT_SVH
`define MULTI_ALARM_MINUTE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define MAMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MAMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MAMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/mams_pkg.sv =====
`default_nettype none

package mams_pkg;

    localparam int DEF_MAX_ALARMS   = 16;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int MINUTES_PER_DAY  = 60 * 24;
    localparam int SNOOZE_STEP      = 10;
    localparam int MAX_REPORTS      = 16;
    localparam int HOURS_MAX        = 31;

    localparam int MINUTE_W = 11;
    localparam int HOURS_W  = 5;
    localparam int MINS_W   = 6;
    localparam int SLOT_W   = 4;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SNOOZE = 2'd2;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_TRIG = 1'b1;

    typedef struct packed {
        logic               snoozeable;
        logic [HOURS_W-1:0] hours;
        logic [MINS_W-1:0]  minutes;
    } t_entry;

    typedef struct packed {
        logic   match;
        t_entry snoozed;
    } t_calc;

endpackage

`default_nettype wire

// ===== design/mams_ram.sv =====
`default_nettype none

module mams_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mams_calc.sv =====
`default_nettype none

module mams_calc (
    input  wire mams_pkg::t_entry               i_entry,
    input  wire logic [mams_pkg::MINUTE_W-1:0]  i_minute,
    output mams_pkg::t_calc                     o_calc
);

    import mams_pkg::*;

    logic [MINUTE_W-1:0] w_time;
    logic [6:0]          w_min_sum;
    logic                w_wrap;
    logic [6:0]          w_min_new;
    logic [5:0]          w_hour_sum;

    always_comb begin
        // hours * 60 as (hours * 64) - (hours * 4)
        w_time = MINUTE_W'({i_entry.hours, 6'b0}) - MINUTE_W'({i_entry.hours, 2'b0})
                 + MINUTE_W'(i_entry.minutes);

        w_min_sum  = 7'(i_entry.minutes) + 7'(SNOOZE_STEP);
        w_wrap     = (w_min_sum >= 7'(MINUTES_PER_HOUR));
        w_min_new  = w_wrap ? (w_min_sum - 7'(MINUTES_PER_HOUR)) : w_min_sum;
        w_hour_sum = 6'(i_entry.hours) + 6'(w_wrap);

        o_calc.match              = (w_time == i_minute);
        o_calc.snoozed.snoozeable = i_entry.snoozeable;
        o_calc.snoozed.minutes    = w_min_new[MINS_W-1:0];
        o_calc.snoozed.hours      = (w_hour_sum > 6'(HOURS_MAX)) ? HOURS_W'(HOURS_MAX)
                                                                 : w_hour_sum[HOURS_W-1:0];
    end

endmodule

`default_nettype wire

// ===== design/multi_alarm_minute_scheduler.sv =====
//  Channel   Direction  Handshake                   Payload
//  request   in         i_in_valid / o_in_stall     i_opcode .. i_snooze_yes
//  result    out        o_out_valid / i_out_stall   o_kind .. o_last
//
//  An add passes through S_ADD, a snooze through S_SNZ_RD and S_SNZ_WR; an ignored request stays idle.
//  A tick walks the alarm memory through its single read port, one entry per cycle while no
//  stall holds the walk; its last report is loaded as it goes from S_FLUSH back to idle.
//  A pending clear adds a walk of the list in S_CLEAR before the add or tick.
//  Reset is synchronous and active low; the alarm memory itself is never cleared.
//  A stalled result holds the output register and, where a further report is due, the walk.
`default_nettype none

`include "multi_alarm_minute_scheduler_assert.svh"

module multi_alarm_minute_scheduler #(
    parameter int MAX_ALARMS = mams_pkg::DEF_MAX_ALARMS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic                               i_new_type,
    input  wire logic [mams_pkg::HOURS_W-1:0]       i_new_hours,
    input  wire logic [mams_pkg::MINS_W-1:0]        i_new_minutes,
    input  wire logic [mams_pkg::SLOT_W-1:0]        i_position,
    input  wire logic                               i_snooze_yes,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_kind,
    output logic                                    o_list_full,
    output logic [mams_pkg::SLOT_W-1:0]             o_slot,
    output logic                                    o_alarm_kind,
    output logic [mams_pkg::HOURS_W-1:0]            o_hours,
    output logic [mams_pkg::MINS_W-1:0]             o_minutes,
    output logic                                    o_last
);

    import mams_pkg::*;

    // Index into the list, count of entries (which can reach the depth) and report count.
    localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CW = $clog2(MAX_ALARMS + 1);
    localparam int RW = $clog2(MAX_REPORTS + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_ADD,
        S_TICK,
        S_FLUSH,
        S_SNZ_RD,
        S_SNZ_WR
    } t_state;

    t_state              r_state;
    logic [MINUTE_W-1:0] r_minute;
    logic [CW-1:0]       r_count;
    logic                r_clear;

    // Captured request.
    logic [1:0]          r_op;
    t_entry              r_new;
    logic [IW-1:0]       r_pos;

    // Memory walk used both by the clear pass and by a tick.
    logic [CW-1:0]       r_rd_idx;
    logic                r_dat_v;
    logic [IW-1:0]       r_dat_idx;
    logic [CW-1:0]       r_keep;

    // A tick report is held back one match so that the final one can carry the last mark.
    logic                r_pend_v;
    t_entry              r_pend;
    logic [SLOT_W-1:0]   r_pend_slot;
    logic [RW-1:0]       r_nrep;

    logic                r_out_valid;
    logic                r_out_kind;
    logic                r_out_full;
    logic [SLOT_W-1:0]   r_out_slot;
    t_entry              r_out_entry;
    logic                r_out_last;

    logic                w_rd_en;
    logic [IW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic [IW-1:0]       w_wr_addr;
    t_entry              w_wr_data;
    logic [EW-1:0]       w_rd_data;
    t_entry              w_q;
    t_calc               w_calc;

    logic                w_out_free;
    logic                w_out_load;
    logic                w_full;
    logic                w_hit;
    logic                w_adv;
    logic                w_walk_more;
    logic [7:0]          w_count_ext;
    logic [7:0]          w_dat_ext;
    logic [7:0]          w_pos_ext;
    logic [11:0]         w_min_inc;

    assign w_q = w_rd_data;

    mams_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ALARMS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // One shared unit compares the entry just read with the minute counter and also
    // forms its snoozed time for the write-back.
    mams_calc u_calc (
        .i_entry  (w_q),
        .i_minute (r_minute),
        .o_calc   (w_calc)
    );

    always_comb begin
        w_out_free  = !r_out_valid || !i_out_stall;
        w_full      = (r_count == CW'(MAX_ALARMS));
        w_hit       = r_dat_v && w_calc.match;
        // A second match cannot be taken while the held report has nowhere to go.
        w_adv       = !(w_hit && r_pend_v && !w_out_free);
        w_walk_more = (r_rd_idx < r_count);
        w_count_ext = 8'(r_count);
        w_dat_ext   = 8'(r_dat_idx);
        w_pos_ext   = 8'(i_position);
        w_min_inc   = 12'(r_minute) + 12'd1;

        w_rd_en    = 1'b0;
        w_rd_addr  = r_rd_idx[IW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_keep[IW-1:0];
        w_wr_data  = w_q;
        w_out_load = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_rd_en   = w_walk_more;
                // Survivors move down to the next free place; it never passes the read.
                w_wr_en   = r_dat_v && !w_q.snoozeable;
                w_wr_addr = r_keep[IW-1:0];
                w_wr_data = w_q;
            end
            S_ADD: begin
                w_wr_en    = w_out_free && !w_full;
                w_wr_addr  = r_count[IW-1:0];
                w_wr_data  = r_new;
                w_out_load = w_out_free;
            end
            S_TICK: begin
                w_rd_en    = w_adv && w_walk_more;
                w_out_load = w_adv && w_hit && r_pend_v;
            end
            S_FLUSH: begin
                w_out_load = r_pend_v && w_out_free;
            end
            S_SNZ_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_pos;
            end
            S_SNZ_WR: begin
                w_wr_en   = w_q.snoozeable;
                w_wr_addr = r_pos;
                w_wr_data = w_calc.snoozed;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_minute    <= '0;
            r_count     <= '0;
            r_clear     <= 1'b0;
            r_dat_v     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_nrep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op               <= i_opcode;
                        r_new.snoozeable   <= i_new_type;
                        r_new.hours        <= i_new_hours;
                        r_new.minutes      <= i_new_minutes;
                        r_pos              <= w_pos_ext[IW-1:0];
                        r_rd_idx           <= '0;
                        r_dat_v            <= 1'b0;
                        r_keep             <= '0;
                        r_nrep             <= '0;
                        r_pend_v           <= 1'b0;
                        case (i_opcode)
                            OP_ADD: begin
                                r_state <= r_clear ? S_CLEAR : S_ADD;
                            end
                            OP_TICK: begin
                                r_state <= r_clear ? S_CLEAR : S_TICK;
                            end
                            OP_SNOOZE: begin
                                // Only a request that names a stored entry goes to memory.
                                if (i_snooze_yes && (w_pos_ext < w_count_ext)) begin
                                    r_state <= S_SNZ_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_CLEAR: begin
                    if (w_rd_en) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    r_dat_v <= w_rd_en;
                    if (w_wr_en) begin
                        r_keep <= r_keep + CW'(1);
                    end
                    if (!w_walk_more && !r_dat_v) begin
                        r_count  <= r_keep;
                        r_clear  <= 1'b0;
                        r_rd_idx <= '0;
                        r_state  <= (r_op == OP_ADD) ? S_ADD : S_TICK;
                    end
                end

                S_ADD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_ACK;
                        r_out_full  <= w_full;
                        r_out_slot  <= w_full ? '0 : w_count_ext[SLOT_W-1:0];
                        r_out_entry <= r_new;
                        r_out_last  <= 1'b1;
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_TICK: begin
                    if (w_adv) begin
                        if (w_rd_en) begin
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end
                        r_dat_v   <= w_rd_en;
                        r_dat_idx <= r_rd_idx[IW-1:0];
                        if (w_hit) begin
                            if (r_pend_v) begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= KIND_TRIG;
                                r_out_full  <= 1'b0;
                                r_out_slot  <= r_pend_slot;
                                r_out_entry <= r_pend;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_v    <= 1'b1;
                            r_pend      <= w_q;
                            r_pend_slot <= w_dat_ext[SLOT_W-1:0];
                            r_nrep      <= r_nrep + RW'(1);
                            // The report limit ends the walk; a read in flight is dropped.
                            if (r_nrep == RW'(MAX_REPORTS - 1)) begin
                                r_state <= S_FLUSH;
                            end
                        end else if (!w_walk_more && !r_dat_v) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end

                S_FLUSH: begin
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_TRIG;
                            r_out_full  <= 1'b0;
                            r_out_slot  <= r_pend_slot;
                            r_out_entry <= r_pend;
                            r_out_last  <= 1'b1;
                        end
                        r_pend_v <= 1'b0;
                        // The day wraps here and arms the clear for the next add or tick.
                        if (w_min_inc >= 12'(MINUTES_PER_DAY)) begin
                            r_minute <= '0;
                            r_clear  <= 1'b1;
                        end else begin
                            r_minute <= w_min_inc[MINUTE_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_SNZ_RD: begin
                    r_state <= S_SNZ_WR;
                end

                S_SNZ_WR: begin
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_list_full  = r_out_full;
    assign o_slot       = r_out_slot;
    assign o_alarm_kind = r_out_entry.snoozeable;
    assign o_hours      = r_out_entry.hours;
    assign o_minutes    = r_out_entry.minutes;
    assign o_last       = r_out_last;

    // Accesses are sequenced so that no write meets a read of the same entry.
    `MAMS_ASSERT(a_no_rw_clash, i_clk, i_rst_n, !(w_wr_en && w_rd_en && (w_wr_addr == w_rd_addr)), "memory read and write hit the same entry")
    `MAMS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_ALARMS), "entry count beyond list depth")
    `MAMS_ASSERT(a_minute_bound, i_clk, i_rst_n, r_minute < MINUTE_W'(MINUTES_PER_DAY), "minute counter out of day")
    `MAMS_ASSERT(a_no_lost_report, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pend_v, "held report left behind after a tick")
    `MAMS_ASSERT(a_report_limit, i_clk, i_rst_n, r_nrep <= RW'(MAX_REPORTS), "too many reports in one tick")

endmodule

`default_nettype wire
